// File: rtl/core/dqkd_pkg.sv
// ----------------------------------------------------------------------------
// dqkd_pkg
// Types and constants shared by the keyed deque block: sizes, opcodes,
// status codes, controller states and the command and response words.
// ----------------------------------------------------------------------------
package dqkd_pkg;

  // record store sizing
  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 24;
  localparam int DATA_BITS = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int REC_BITS  = KEY_BITS + DATA_BITS;

  // command opcodes
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_DELETE_KEY = 2'd3
  } dqkd_op_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } dqkd_status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_LOAD_HEAD,
    S_RESP
  } dqkd_state_t;

  // command word
  typedef struct packed {
    dqkd_op_t              opcode;
    logic [KEY_BITS-1:0]   entry_key;
    logic [DATA_BITS-1:0]  entry_data;
  } dqkd_cmd_t;

  // response word
  typedef struct packed {
    dqkd_status_t          status;
    logic                  removed_valid;
    logic [KEY_BITS-1:0]   removed_key;
    logic [DATA_BITS-1:0]  removed_data;
    logic                  front_valid;
    logic [KEY_BITS-1:0]   front_key;
    logic [DATA_BITS-1:0]  front_data;
    logic [CNT_BITS-1:0]   occupancy;
  } dqkd_rsp_t;

endpackage

// File: rtl/core/dqkd_ram.sv
// ----------------------------------------------------------------------------
// dqkd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module dqkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/deque_with_key_delete_unit.sv
// ----------------------------------------------------------------------------
// deque_with_key_delete_unit
// Bounded deque of key/payload records with delete of the first matching key.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (opcode, key, payload) is taken at a clock edge where start
//   is high and busy is low. Exactly one response word follows on rsp, marked
//   by done for a single cycle. The receiver cannot stall: the response must
//   be captured in the cycle that done is high.
// Steps from the accepting edge to the done cycle, done registered from S_RESP:
//   push: S_ALLOC then S_RESP, or S_RESP alone when full
//   pop front: S_WALK, S_LOAD_HEAD when a new head record must be fetched, S_RESP
//   delete: S_WALK from the head to the first match or, on a miss, the last
//   record; S_LOAD_HEAD when the head is removed and a record remains; S_RESP.
//   The walk visits one linked slot per cycle, limited by the registered
//   reads of the record and link RAMs.
//   Empty or full rejections go straight to S_RESP. busy stays high until the done
//   cycle; a new command may be accepted in that cycle.
// Reset:
//   rst empties the store at once. The free slot stack needs no clearing
//   pass: entries below its low-water mark read back their initial slot
//   numbers, so a command can be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module deque_with_key_delete_unit
  import dqkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dqkd_cmd_t cmd,
  output logic      done,
  output dqkd_rsp_t rsp
);

  localparam logic [CNT_BITS-1:0] CAP_C = CNT_BITS'(CAPACITY);
  localparam logic [CNT_BITS-1:0] ONE_C = CNT_BITS'(1);

  // control registers
  dqkd_state_t         state, state_next;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] low_water;
  logic [IDX_BITS-1:0] head, tail;
  logic [IDX_BITS-1:0] cur, prev;
  logic [CNT_BITS-1:0] walk_pos;

  // payload registers
  dqkd_cmd_t           cmd_r;
  logic [KEY_BITS-1:0] head_key;
  logic [DATA_BITS-1:0] head_data;
  dqkd_status_t        status_r;
  logic                rem_valid;
  logic [KEY_BITS-1:0] rem_key;
  logic [DATA_BITS-1:0] rem_data;

  // ram ports
  logic                rec_we, nxt_we, free_we;
  logic [IDX_BITS-1:0] rec_waddr, nxt_waddr, free_waddr;
  logic [REC_BITS-1:0] rec_wdata;
  logic [IDX_BITS-1:0] nxt_wdata;
  logic [IDX_BITS-1:0] link_raddr;
  logic [REC_BITS-1:0] rec_rdata;
  logic [IDX_BITS-1:0] nxt_rdata, free_rdata;

  // derived values
  logic [CNT_BITS-1:0] free_pop_full;
  logic [IDX_BITS-1:0] free_pop_idx;
  logic [CNT_BITS-1:0] free_push_full;
  logic [CNT_BITS-1:0] init_slot_full;
  logic                fresh_entry;
  logic [IDX_BITS-1:0] alloc_slot;
  logic [KEY_BITS-1:0] rd_key;
  logic [DATA_BITS-1:0] rd_data;
  logic                walk_match;
  logic                walk_last;

  // record store: key and payload per slot
  dqkd_ram #(.WIDTH(REC_BITS), .DEPTH(CAPACITY)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (link_raddr),
    .rdata (rec_rdata)
  );

  // successor links
  dqkd_ram #(.WIDTH(IDX_BITS), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (link_raddr),
    .rdata (nxt_rdata)
  );

  // free slot stack
  dqkd_ram #(.WIDTH(IDX_BITS), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (cur),
    .raddr (free_pop_idx),
    .rdata (free_rdata)
  );

  // free stack pointers: the stack holds CAPACITY - count entries, top at CAPACITY - 1 - count
  assign free_pop_full  = CAP_C - ONE_C - count;
  assign free_pop_idx   = free_pop_full[IDX_BITS-1:0];
  assign free_push_full = CAP_C - count;
  assign free_waddr     = free_push_full[IDX_BITS-1:0];

  // entries below the low-water mark still hold their initial slot number
  assign init_slot_full = CAP_C - ONE_C - CNT_BITS'(free_pop_idx);
  assign fresh_entry    = CNT_BITS'(free_pop_idx) < low_water;
  assign alloc_slot     = fresh_entry ? init_slot_full[IDX_BITS-1:0] : free_rdata;

  // walk compare
  assign rd_key     = rec_rdata[REC_BITS-1:DATA_BITS];
  assign rd_data    = rec_rdata[DATA_BITS-1:0];
  assign walk_match = (cmd_r.opcode == OP_POP_FRONT) || (rd_key == cmd_r.entry_key);
  assign walk_last  = (walk_pos + ONE_C) == count;

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram controls
  always_comb begin
    state_next = state;
    rec_we     = 1'b0;
    rec_waddr  = alloc_slot;
    rec_wdata  = {cmd_r.entry_key, cmd_r.entry_data};
    nxt_we     = 1'b0;
    nxt_waddr  = tail;
    nxt_wdata  = alloc_slot;
    free_we    = 1'b0;
    link_raddr = head;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              state_next = (count == CAP_C) ? S_RESP : S_ALLOC;
            end
            OP_POP_FRONT, OP_DELETE_KEY: begin
              state_next = (count == '0) ? S_RESP : S_WALK;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_ALLOC: begin
        rec_we = 1'b1;
        if (count != '0) begin
          nxt_we = 1'b1;
          if (cmd_r.opcode == OP_PUSH_FRONT) begin
            nxt_waddr = alloc_slot;
            nxt_wdata = head;
          end
        end
        state_next = S_RESP;
      end
      S_WALK: begin
        // follow the successor link every cycle
        link_raddr = nxt_rdata;
        if (walk_match) begin
          free_we = 1'b1;
          if (walk_pos == '0) begin
            state_next = (count == ONE_C) ? S_RESP : S_LOAD_HEAD;
          end else begin
            nxt_we     = 1'b1;
            nxt_waddr  = prev;
            nxt_wdata  = nxt_rdata;
            state_next = S_RESP;
          end
        end else if (walk_last) begin
          state_next = S_RESP;
        end
      end
      S_LOAD_HEAD: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      low_water <= CAP_C;
      head      <= '0;
      tail      <= '0;
      done      <= 1'b0;
    end else begin
      done <= (state == S_RESP);
      case (state)
        S_ALLOC: begin
          count <= count + ONE_C;
          if (fresh_entry) begin
            low_water <= CNT_BITS'(free_pop_idx);
          end
          if (count == '0) begin
            head <= alloc_slot;
            tail <= alloc_slot;
          end else if (cmd_r.opcode == OP_PUSH_FRONT) begin
            head <= alloc_slot;
          end else begin
            tail <= alloc_slot;
          end
        end
        S_WALK: begin
          if (walk_match) begin
            count <= count - ONE_C;
            if (walk_pos == '0) begin
              head <= nxt_rdata;
            end else if (walk_last) begin
              tail <= prev;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r     <= cmd;
        cur       <= head;
        prev      <= head;
        walk_pos  <= '0;
        rem_valid <= 1'b0;
        rem_key   <= '0;
        rem_data  <= '0;
        if ((cmd.opcode == OP_PUSH_BACK) || (cmd.opcode == OP_PUSH_FRONT)) begin
          status_r <= (count == CAP_C) ? ST_FULL : ST_OK;
        end else begin
          status_r <= (count == '0) ? ST_EMPTY : ST_OK;
        end
      end
      S_ALLOC: begin
        if ((count == '0) || (cmd_r.opcode == OP_PUSH_FRONT)) begin
          head_key  <= cmd_r.entry_key;
          head_data <= cmd_r.entry_data;
        end
      end
      S_WALK: begin
        if (walk_match) begin
          rem_valid <= 1'b1;
          rem_key   <= rd_key;
          rem_data  <= rd_data;
        end else if (walk_last) begin
          status_r <= ST_NOTFOUND;
        end else begin
          prev     <= cur;
          cur      <= nxt_rdata;
          walk_pos <= walk_pos + ONE_C;
        end
      end
      S_LOAD_HEAD: begin
        head_key  <= rd_key;
        head_data <= rd_data;
      end
      S_RESP: begin
        rsp.status        <= status_r;
        rsp.removed_valid <= rem_valid;
        rsp.removed_key   <= rem_key;
        rsp.removed_data  <= rem_data;
        rsp.front_valid   <= (count != '0);
        rsp.front_key     <= (count != '0) ? head_key : '0;
        rsp.front_data    <= (count != '0) ? head_data : '0;
        rsp.occupancy     <= count;
      end
      default: ;
    endcase
  end

endmodule

// File: verif/tb_deque_with_key_delete_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deque_with_key_delete_unit
// Self-checking bench for the keyed deque. A short table of directed commands
// covers the empty, not-found and extreme-value cases. It is followed by
// random fill, drain and mixed episodes. Each response word is checked field
// by field against a typed row's word, else a queue-based store predictor.
// ----------------------------------------------------------------------------
module tb_deque_with_key_delete_unit;
  import dqkd_pkg::*;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
  } record_t;

  typedef struct packed {
    dqkd_cmd_t cmd;
    logic      typed;
    dqkd_rsp_t rsp;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  dqkd_cmd_t cmd;
  logic      done;
  dqkd_rsp_t rsp;

  record_t   held_records[$];
  dqkd_rsp_t pending_rsp[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        idle_pct;
  int        random_sent;

  deque_with_key_delete_unit uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted response word; updates the held records
  function automatic dqkd_rsp_t next_response(dqkd_cmd_t c);
    dqkd_rsp_t r;
    record_t   gone;
    int        hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (c.opcode)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (held_records.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (c.opcode == OP_PUSH_BACK) begin
          held_records.push_back({c.entry_key, c.entry_data});
        end else begin
          held_records.push_front({c.entry_key, c.entry_data});
        end
      end
      OP_POP_FRONT: begin
        if (held_records.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          gone = held_records.pop_front();
          r.removed_valid = 1'b1;
          r.removed_key = gone.key;
          r.removed_data = gone.data;
        end
      end
      default: begin
        if (held_records.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < held_records.size(); i++) begin
            if (hit < 0 && held_records[i].key == c.entry_key) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            gone = held_records[hit];
            held_records.delete(hit);
            r.removed_valid = 1'b1;
            r.removed_key = gone.key;
            r.removed_data = gone.data;
          end
        end
      end
    endcase
    if (held_records.size() > 0) begin
      r.front_valid = 1'b1;
      r.front_key = held_records[0].key;
      r.front_data = held_records[0].data;
    end
    r.occupancy = CNT_BITS'(held_records.size());
    return r;
  endfunction

  function automatic dqkd_rsp_t mk_rsp(dqkd_status_t st, logic rv, logic [KEY_BITS-1:0] rk,
                                       logic [DATA_BITS-1:0] rd, logic fv,
                                       logic [KEY_BITS-1:0] fk, logic [DATA_BITS-1:0] fd,
                                       int occ);
    dqkd_rsp_t r;
    r.status = st;
    r.removed_valid = rv;
    r.removed_key = rk;
    r.removed_data = rd;
    r.front_valid = fv;
    r.front_key = fk;
    r.front_data = fd;
    r.occupancy = CNT_BITS'(occ);
    return r;
  endfunction

  task automatic add_row(dqkd_op_t op, logic [KEY_BITS-1:0] k, logic [DATA_BITS-1:0] d,
                         logic typed, dqkd_rsp_t want);
    stim_row_t row;
    row.cmd.opcode = op;
    row.cmd.entry_key = k;
    row.cmd.entry_data = d;
    row.typed = typed;
    row.rsp = want;
    directed_rows.push_back(row);
  endtask

  // keys from a small pool half the time so duplicates and hits are common
  function automatic logic [KEY_BITS-1:0] pick_key();
    logic hi;
    hi = ($urandom_range(1) == 1);
    if ($urandom_range(1) == 1) return {{(KEY_BITS-3){hi}}, 3'($urandom_range(7))};
    return KEY_BITS'($urandom());
  endfunction

  // mostly the key of a held record, deep positions included
  function automatic logic [KEY_BITS-1:0] pick_delete_key();
    if (held_records.size() > 0 && $urandom_range(99) < 80)
      return held_records[$urandom_range(held_records.size() - 1)].key;
    return pick_key();
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // response checker: one word per done strobe
  always @(posedge clk) begin
    dqkd_rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response word: expected none, actual %h", $time, rsp);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("removed_valid", want.removed_valid, rsp.removed_valid);
        check_field("removed_key", want.removed_key, rsp.removed_key);
        check_field("removed_data", want.removed_data, rsp.removed_data);
        check_field("front_valid", want.front_valid, rsp.front_valid);
        check_field("front_key", want.front_key, rsp.front_key);
        check_field("front_data", want.front_data, rsp.front_data);
        check_field("occupancy", want.occupancy, rsp.occupancy);
      end
    end
  end

  // drive one command word and hold it until taken
  task automatic issue(dqkd_op_t op, logic [KEY_BITS-1:0] k, logic [DATA_BITS-1:0] d,
                       logic typed, dqkd_rsp_t want);
    dqkd_cmd_t c;
    dqkd_rsp_t pred;
    c.opcode = op;
    c.entry_key = k;
    c.entry_data = d;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pred = next_response(c);
    pending_rsp.push_back(typed ? want : pred);
    // random sender gaps
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // hold off until every outstanding word has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int mode;
    int count;
    int pick;
    dqkd_op_t op;
    logic [KEY_BITS-1:0] k;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    mismatch_count = 0;
    idle_pct = 0;
    random_sent = 0;

    // directed table
    add_row(OP_POP_FRONT, 24'h000000, 32'h0, 1'b1, mk_rsp(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
    add_row(OP_DELETE_KEY, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1,
            mk_rsp(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
    add_row(OP_PUSH_BACK, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1,
            mk_rsp(ST_OK, 0, 0, 0, 1, 24'hFFFFFF, 32'hFFFFFFFF, 1));
    add_row(OP_PUSH_FRONT, 24'h000000, 32'h0, 1'b1, mk_rsp(ST_OK, 0, 0, 0, 1, 0, 0, 2));
    add_row(OP_DELETE_KEY, 24'h123456, 32'h0, 1'b1,
            mk_rsp(ST_NOTFOUND, 0, 0, 0, 1, 0, 0, 2));
    add_row(OP_DELETE_KEY, 24'hFFFFFF, 32'h0, 1'b1,
            mk_rsp(ST_OK, 1, 24'hFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 1));
    add_row(OP_POP_FRONT, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1,
            mk_rsp(ST_OK, 1, 0, 0, 0, 0, 0, 0));
    add_row(OP_PUSH_BACK, 24'hAAAAAA, 32'h55555555, 1'b0, '0);
    add_row(OP_PUSH_FRONT, 24'h555555, 32'hAAAAAAAA, 1'b0, '0);
    add_row(OP_PUSH_BACK, 24'hAAAAAA, 32'h12345678, 1'b0, '0);
    add_row(OP_PUSH_BACK, 24'h000001, 32'h80000000, 1'b0, '0);
    add_row(OP_DELETE_KEY, 24'hAAAAAA, 32'h0, 1'b0, '0);
    add_row(OP_DELETE_KEY, 24'h000001, 32'h0, 1'b0, '0);
    add_row(OP_DELETE_KEY, 24'h555555, 32'h0, 1'b0, '0);
    add_row(OP_PUSH_FRONT, 24'h800000, 32'h00000001, 1'b0, '0);
    add_row(OP_DELETE_KEY, 24'h7FFFFF, 32'h0, 1'b0, '0);
    add_row(OP_POP_FRONT, 24'h0, 32'h0, 1'b0, '0);
    add_row(OP_DELETE_KEY, 24'h800000, 32'h0, 1'b0, '0);
    add_row(OP_DELETE_KEY, 24'hAAAAAA, 32'h0, 1'b0, '0);
    add_row(OP_POP_FRONT, 24'h0, 32'h0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd.opcode, directed_rows[i].cmd.entry_key,
            directed_rows[i].cmd.entry_data, directed_rows[i].typed, directed_rows[i].rsp);
    wait_drained();

    // random episodes: fill to full, drain to empty, or mixed traffic
    while (random_sent < 600) begin
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 69;
        default: idle_pct = 35;
      endcase
      if ($urandom_range(5) == 0) wait_drained();
      mode = $urandom_range(3);
      if (mode == 0) count = CAPACITY - held_records.size() + $urandom_range(1, 4);
      else if (mode == 1) count = held_records.size() + $urandom_range(1, 3);
      else count = $urandom_range(10, 60);
      repeat (count) begin
        pick = $urandom_range(99);
        if (mode == 0) begin
          op = (pick < 50) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else if (mode == 1) begin
          op = (pick < 50) ? OP_POP_FRONT : OP_DELETE_KEY;
        end else begin
          op = dqkd_op_t'($urandom_range(3));
        end
        k = (op == OP_DELETE_KEY) ? pick_delete_key() : pick_key();
        issue(op, k, DATA_BITS'($urandom()), 1'b0, '0);
        random_sent++;
      end
    end

    // let the last words come back, then watch for strays
    wait_drained();
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: deque_with_key_delete_unit.f
rtl/core/dqkd_pkg.sv
rtl/core/dqkd_ram.sv
rtl/core/deque_with_key_delete_unit.sv
verif/tb_deque_with_key_delete_unit.sv
